// ===== rtl/usr_pkg.sv =====
package usr_pkg;

	// Units per item and derived widths
	localparam int LANES      = 4;
	localparam int LANE_IDX_W = $clog2(LANES);
	localparam int COUNT_W    = 3;
	localparam int UNIT_W     = 16;

	// Result queue sizing: room for two results from one transfer
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// Surrogate tags and replacement character in both byte orders
	localparam logic [UNIT_W-1:0] SURR_MASK    = 16'hFC00;
	localparam logic [UNIT_W-1:0] HIGH_TAG     = 16'hD800;
	localparam logic [UNIT_W-1:0] LOW_TAG      = 16'hDC00;
	localparam logic [UNIT_W-1:0] REPL_NATIVE  = 16'hFFFD;
	localparam logic [UNIT_W-1:0] REPL_SWAPPED = 16'hFDFF;

	typedef logic [UNIT_W-1:0] unit_t;

	typedef struct packed {
		unit_t              unit_a;
		unit_t              unit_b;
		unit_t              unit_c;
		unit_t              unit_d;
		logic [COUNT_W-1:0] unit_count;
		logic               last_item;
	} item_t;

	typedef struct packed {
		unit_t              fixed_a;
		unit_t              fixed_b;
		unit_t              fixed_c;
		unit_t              fixed_d;
		logic [COUNT_W-1:0] fixed_count;
		logic               end_of_string;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} push_t;

	function automatic unit_t unit_value(input unit_t raw, input logic swapped);
		return swapped ? {raw[7:0], raw[15:8]} : raw;
	endfunction

	function automatic logic is_high(input unit_t raw, input logic swapped);
		return (unit_value(raw, swapped) & SURR_MASK) == HIGH_TAG;
	endfunction

	function automatic logic is_low(input unit_t raw, input logic swapped);
		return (unit_value(raw, swapped) & SURR_MASK) == LOW_TAG;
	endfunction

endpackage

// ===== rtl/utf16_surrogate_repair.sv =====
// UTF-16 unpaired-surrogate repair.
// Items of four code units enter on item/item_valid/item_stall; a transfer
// happens at a clock edge with item_valid high and item_stall low. Repaired
// items leave on result/result_valid/result_stall under the same rule.
// The byte-order register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high; it must be written only while the block is idle, which the block itself does not enforce.
// Throughput: one item per cycle while item_stall is low. Each item is held
// until the first unit of the next item is known, so its result is written
// into the result queue at the next item's transfer. A last item releases
// both the held result and its own, the held one first; the two results go
// into a four-entry result queue together, which lets one item per cycle flow
// in steady state. Pairing is judged by four lane units for the held item
// and four for the incoming one, working side by side.
// item_stall rises when the result queue has fewer than two free entries,
// so a stalled receiver backs up the input after at most four more items.
// Reset clears the held item, the pairing state, the queue and the
// byte-order register (native order).
module utf16_surrogate_repair
	import usr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data
);

	logic               byte_swapped_q;
	unit_t              held_units_q [LANES];
	logic [COUNT_W-1:0] held_count_q;
	logic               held_valid_q;
	logic               before_is_high_q;

	unit_t              cur_units [LANES];
	logic [COUNT_W-1:0] cur_n;
	logic               accept;
	logic               space;
	logic               prev_high;
	logic [COUNT_W-1:0] held_last;

	logic               held_hi [LANES];
	logic               held_lo [LANES];
	unit_t              held_fix [LANES];
	logic               cur_hi [LANES];
	logic               cur_lo [LANES];
	unit_t              cur_fix [LANES];

	result_t            held_res;
	result_t            cur_res;
	push_t              push_a;
	push_t              push_b;

	assign cfg_ready  = 1'b1;
	assign item_stall = !space;
	assign accept     = item_valid && space;

	assign cur_units[0] = item.unit_a;
	assign cur_units[1] = item.unit_b;
	assign cur_units[2] = item.unit_c;
	assign cur_units[3] = item.unit_d;

	// Clamp the unit count to one..LANES
	always_comb begin
		if (item.unit_count == '0) begin
			cur_n = COUNT_W'(1);
		end else if (item.unit_count > COUNT_W'(LANES)) begin
			cur_n = COUNT_W'(LANES);
		end else begin
			cur_n = item.unit_count;
		end
	end

	// Pairing context for the incoming item
	assign held_last = held_count_q - COUNT_W'(1);
	assign prev_high = held_valid_q ? held_hi[held_last[LANE_IDX_W-1:0]] : before_is_high_q;

	// Lanes for the held item and the incoming item
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic h_prev;
		logic h_next;
		logic c_prev;
		logic c_next;

		if (i == 0) begin : g_first
			assign h_prev = before_is_high_q;
			assign c_prev = prev_high;
		end else begin : g_rest
			assign h_prev = held_hi[i-1];
			assign c_prev = cur_hi[i-1];
		end

		if (i + 1 < LANES) begin : g_inner
			assign h_next = (COUNT_W'(i + 1) < held_count_q) ? held_lo[i+1] : cur_lo[0];
			assign c_next = (COUNT_W'(i + 1) < cur_n) ? cur_lo[i+1] : 1'b0;
		end else begin : g_edge
			assign h_next = cur_lo[0];
			assign c_next = 1'b0;
		end

		usr_lane u_held (
			.raw       (held_units_q[i]),
			.swapped   (byte_swapped_q),
			.active    (COUNT_W'(i) < held_count_q),
			.prev_high (h_prev),
			.next_low  (h_next),
			.hi        (held_hi[i]),
			.lo        (held_lo[i]),
			.fixed     (held_fix[i])
		);

		usr_lane u_cur (
			.raw       (cur_units[i]),
			.swapped   (byte_swapped_q),
			.active    (COUNT_W'(i) < cur_n),
			.prev_high (c_prev),
			.next_low  (c_next),
			.hi        (cur_hi[i]),
			.lo        (cur_lo[i]),
			.fixed     (cur_fix[i])
		);
	end

	// Merge lane outputs into results
	always_comb begin
		held_res.fixed_a       = held_fix[0];
		held_res.fixed_b       = held_fix[1];
		held_res.fixed_c       = held_fix[2];
		held_res.fixed_d       = held_fix[3];
		held_res.fixed_count   = held_count_q;
		held_res.end_of_string = 1'b0;

		cur_res.fixed_a        = cur_fix[0];
		cur_res.fixed_b        = cur_fix[1];
		cur_res.fixed_c        = cur_fix[2];
		cur_res.fixed_d        = cur_fix[3];
		cur_res.fixed_count    = cur_n;
		cur_res.end_of_string  = 1'b1;
	end

	// Queue the held result first, then the last item's own
	always_comb begin
		push_a.valid = accept && (held_valid_q || item.last_item);
		push_a.data  = held_valid_q ? held_res : cur_res;
		push_b.valid = accept && held_valid_q && item.last_item;
		push_b.data  = cur_res;
	end

	usr_rq u_rq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_a       (push_a),
		.push_b       (push_b),
		.space        (space),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Hold the units of a non-last item
	always_ff @(posedge clk) begin
		if (accept && !item.last_item) begin
			held_units_q <= cur_units;
		end
	end

	// Update pairing state and byte order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swapped_q   <= 1'b0;
			held_count_q     <= '0;
			held_valid_q     <= 1'b0;
			before_is_high_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				byte_swapped_q <= cfg_data;
			end
			if (accept) begin
				if (item.last_item) begin
					held_count_q     <= '0;
					held_valid_q     <= 1'b0;
					before_is_high_q <= 1'b0;
				end else begin
					held_count_q     <= cur_n;
					held_valid_q     <= 1'b1;
					before_is_high_q <= prev_high;
				end
			end
		end
	end

endmodule

// ===== rtl/usr_lane.sv =====
module usr_lane
	import usr_pkg::*;
(
	input  unit_t raw,
	input  logic  swapped,
	input  logic  active,
	input  logic  prev_high,
	input  logic  next_low,
	output logic  hi,
	output logic  lo,
	output unit_t fixed
);

	logic ill;

	// Classify this unit for the neighboring lanes
	assign hi = is_high(raw, swapped);
	assign lo = is_low(raw, swapped);

	// Flag a low without a leading high, or a high without a trailing low
	assign ill = (lo && !prev_high) || (hi && !next_low);

	// Replace ill-sequenced units, zero unused lanes
	always_comb begin
		if (!active) begin
			fixed = '0;
		end else if (ill) begin
			fixed = swapped ? REPL_SWAPPED : REPL_NATIVE;
		end else begin
			fixed = raw;
		end
	end

endmodule

// ===== rtl/usr_rq.sv =====
module usr_rq
	import usr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push_a,
	input  push_t   push_b,
	output logic    space,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	result_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] count_q;
	logic [RQ_PTR_W-1:0] wr_ptr_b;
	logic                pop;
	logic [RQ_CNT_W-1:0] n_push;

	assign wr_ptr_b     = wr_ptr_q + RQ_PTR_W'(1);
	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign n_push       = RQ_CNT_W'(push_a.valid) + RQ_CNT_W'(push_b.valid);

	// Accept a new item only with room for two results
	assign space = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));

	// Store results; the second push follows the first
	always_ff @(posedge clk) begin
		if (push_a.valid) begin
			mem_q[wr_ptr_q] <= push_a.data;
		end
		if (push_b.valid) begin
			mem_q[wr_ptr_b] <= push_b.data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - RQ_CNT_W'(pop);
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import usr_pkg::*;

	localparam int          LANE_N   = 4;
	localparam logic [15:0] REPL_NAT = 16'hFFFD;
	localparam logic [15:0] REPL_SW  = 16'hFDFF;

	typedef logic [LANE_N-1:0][15:0] lane_set_t;

	typedef struct packed {
		logic    cfg_row;
		logic    cfg_val;
		item_t   it;
		logic    typed;
		result_t typ;
	} dir_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_valid    = 1'b0;
	logic    cfg_ready;
	logic    cfg_data     = 1'b0;

	// Predictor state
	lane_set_t held_lanes;
	int        held_n;
	bit        held_on;
	bit        prior_lead;
	bit        swapped_mode;

	result_t  mended_q[$];
	dir_row_t steps[$];

	int  errors         = 0;
	int  items_taken    = 0;
	int  results_seen   = 0;
	int  strings_sent   = 0;
	int  burst_left     = 0;
	bit  last_gen_lead  = 0;
	bit  long_hold_done = 0;
	int  hold_left      = 0;
	int  mode_left      = 0;
	int  stall_mode     = 0;

	utf16_surrogate_repair u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// Value order of a raw unit under the current byte order
	function automatic logic [15:0] as_value(input logic [15:0] raw);
		return swapped_mode ? {raw[7:0], raw[15:8]} : raw;
	endfunction

	function automatic bit is_lead(input logic [15:0] raw);
		logic [15:0] v;
		v = as_value(raw);
		return v[15:10] == 6'b110110;
	endfunction

	function automatic bit is_trail(input logic [15:0] raw);
		logic [15:0] v;
		v = as_value(raw);
		return v[15:10] == 6'b110111;
	endfunction

	// Repair one item given its neighbors on both sides
	function automatic result_t mend_block(input lane_set_t u, input int n, input bit prior,
			input bit next_trail, input bit eos);
		lane_set_t v;
		bit        ph;
		bit        nl;
		bit        bad;
		result_t   r;
		for (int i = 0; i < LANE_N; i++) begin
			v[i] = '0;
			if (i < n) begin
				if (i == 0) ph = prior;
				else ph = is_lead(u[i-1]);
				if (i + 1 < n) nl = is_trail(u[i+1]);
				else nl = next_trail;
				bad = (is_trail(u[i]) && !ph) || (is_lead(u[i]) && !nl);
				v[i] = bad ? (swapped_mode ? REPL_SW : REPL_NAT) : u[i];
			end
		end
		r.fixed_a       = v[0];
		r.fixed_b       = v[1];
		r.fixed_c       = v[2];
		r.fixed_d       = v[3];
		r.fixed_count   = n[2:0];
		r.end_of_string = eos;
		return r;
	endfunction

	// Advance the predictor on one accepted item
	task automatic take_item(input item_t it, input bit typed, input result_t typ);
		lane_set_t cur;
		int        n;
		bit        ph;
		result_t   r;
		cur = {it.unit_d, it.unit_c, it.unit_b, it.unit_a};
		n = it.unit_count;
		if (n == 0) n = 1;
		if (n > LANE_N) n = LANE_N;
		ph = prior_lead;
		if (held_on) begin
			mended_q.push_back(mend_block(held_lanes, held_n, prior_lead, is_trail(cur[0]), 1'b0));
			ph = is_lead(held_lanes[held_n-1]);
		end
		if (it.last_item) begin
			r = mend_block(cur, n, ph, 1'b0, 1'b1);
			mended_q.push_back(typed ? typ : r);
			held_on    = 0;
			held_n     = 0;
			prior_lead = 0;
		end else begin
			held_lanes = cur;
			held_n     = n;
			held_on    = 1;
			prior_lead = ph;
		end
	endtask

	function automatic item_t mk(input logic [15:0] a, b, c, d, input int cnt, input bit last);
		item_t it;
		it.unit_a     = a;
		it.unit_b     = b;
		it.unit_c     = c;
		it.unit_d     = d;
		it.unit_count = cnt[2:0];
		it.last_item  = last;
		return it;
	endfunction

	function automatic result_t rs(input logic [15:0] a, b, c, d, input int cnt, input bit eos);
		result_t r;
		r.fixed_a       = a;
		r.fixed_b       = b;
		r.fixed_c       = c;
		r.fixed_d       = d;
		r.fixed_count   = cnt[2:0];
		r.end_of_string = eos;
		return r;
	endfunction

	task automatic add_row(input item_t it, input bit typed, input result_t typ);
		dir_row_t row;
		row.cfg_row = 0;
		row.cfg_val = 0;
		row.it      = it;
		row.typed   = typed;
		row.typ     = typ;
		steps.push_back(row);
	endtask

	task automatic add_cfg(input bit v);
		dir_row_t row;
		row         = '0;
		row.cfg_row = 1;
		row.cfg_val = v;
		steps.push_back(row);
	endtask

	// Offer one item, opening a new burst after a random gap when due
	task automatic offer(input item_t it, input bit typed, input result_t typ);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		take_item(it, typed, typ);
		items_taken++;
	endtask

	// Drop valid and wait until every expected result has come
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (mended_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_order(input bit v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		swapped_mode = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		repeat (3) @(negedge clk);
	endtask

	// Draw a unit, favoring well-formed pairs, in the current byte order
	function automatic logic [15:0] pick_unit();
		int          r;
		logic [15:0] val;
		r = $urandom_range(0, 99);
		if (last_gen_lead && r < 70) val = 16'hDC00 | 16'($urandom_range(0, 1023));
		else if (r < 30) val = 16'($urandom_range(0, 16'hD7FF));
		else if (r < 50) val = 16'hD800 | 16'($urandom_range(0, 1023));
		else if (r < 62) val = 16'hDC00 | 16'($urandom_range(0, 1023));
		else if (r < 72) begin
			case ($urandom_range(0, 5))
				0: val = 16'h0000;
				1: val = 16'hFFFF;
				2: val = 16'hD800;
				3: val = 16'hDBFF;
				4: val = 16'hDC00;
				default: val = 16'hDFFF;
			endcase
		end
		else if (r < 85) val = 16'($urandom_range(16'hE000, 16'hFFFF));
		else begin
			// raw noise, byte order ignored
			val = 16'($urandom_range(0, 16'hFFFF));
			last_gen_lead = is_lead(val);
			return val;
		end
		last_gen_lead = (val[15:10] == 6'b110110);
		return as_value(val);
	endfunction

	// Send one random string, closed by a last item
	task automatic run_string();
		int    len;
		int    cnt;
		bit    last;
		item_t it;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int k = 0; k < len; k++) begin
			last = (k == len - 1);
			if (!last && $urandom_range(0, 99) < 85) cnt = 4;
			else cnt = $urandom_range(0, 7);
			it = mk(pick_unit(), pick_unit(), pick_unit(), pick_unit(), cnt, last);
			offer(it, 1'b0, '0);
		end
		strings_sent++;
	endtask

	// Check each result transfer against the oldest expectation
	task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (mended_q.size() == 0) begin
				$error("result with nothing expected: %h", result);
				errors++;
			end else begin
				want = mended_q.pop_front();
				cmp_field("fixed_a", want.fixed_a, result.fixed_a);
				cmp_field("fixed_b", want.fixed_b, result.fixed_b);
				cmp_field("fixed_c", want.fixed_c, result.fixed_c);
				cmp_field("fixed_d", want.fixed_d, result.fixed_d);
				cmp_field("fixed_count", 16'(want.fixed_count), 16'(result.fixed_count));
				cmp_field("end_of_string", 16'(want.end_of_string), 16'(result.end_of_string));
			end
		end
	end

	// Receiver stall pattern, with one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (!long_hold_done && items_taken >= 700) begin
				long_hold_done = 1;
				hold_left      = 160;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left  = $urandom_range(32, 128);
				end
				mode_left--;
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 7) == 0);
					default: result_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	initial begin
		// directed: after reset, extremes and special cases
		add_row(mk(16'h0041, 16'h0000, 16'h0000, 16'h0000, 1, 1), 1,
			rs(16'h0041, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		add_row(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 1), 1,
			rs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 1));
		add_row(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4, 1), 1,
			rs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4, 1));
		// lone high and lone low
		add_row(mk(16'hD800, 16'h0000, 16'h0000, 16'h0000, 1, 1), 1,
			rs(REPL_NAT, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		add_row(mk(16'hDFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1), 1,
			rs(REPL_NAT, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		// zero count reads as one, oversize count saturates
		add_row(mk(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 0, 1), 1,
			rs(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		add_row(mk(16'h0001, 16'h0002, 16'h0003, 16'h0004, 7, 1), 1,
			rs(16'h0001, 16'h0002, 16'h0003, 16'h0004, 4, 1));
		// good pair, then a dangling high at the end of the string
		add_row(mk(16'hD83D, 16'hDE00, 16'h0041, 16'hDBFF, 4, 1), 1,
			rs(16'hD83D, 16'hDE00, 16'h0041, REPL_NAT, 4, 1));
		// pairing across items, short and oversize non-last items
		add_row(mk(16'h0041, 16'hD800, 16'hDC00, 16'hDBFF, 4, 0), 0, '0);
		add_row(mk(16'hDC01, 16'h0042, 16'hDC00, 16'hD800, 4, 0), 0, '0);
		add_row(mk(16'hDBFF, 16'hAAAA, 16'hBBBB, 16'hCCCC, 1, 0), 0, '0);
		add_row(mk(16'hDC00, 16'hFFFF, 16'h0000, 16'hD800, 3, 1), 0, '0);
		add_row(mk(16'hD800, 16'hD800, 16'hDC00, 16'hD800, 5, 0), 0, '0);
		add_row(mk(16'h0041, 16'hDC00, 16'h0000, 16'h0000, 2, 1), 0, '0);
		// swapped byte order
		add_cfg(1'b1);
		add_row(mk(16'h00D8, 16'h0000, 16'h0000, 16'h0000, 1, 1), 1,
			rs(REPL_SW, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		add_row(mk(16'hD800, 16'h0000, 16'h0000, 16'h0000, 1, 1), 1,
			rs(16'hD800, 16'h0000, 16'h0000, 16'h0000, 1, 1));
		add_row(mk(16'h3DD8, 16'h00DE, 16'h00DC, 16'hFFDB, 4, 0), 0, '0);
		add_row(mk(16'h00DC, 16'h0041, 16'hFFFF, 16'h00D8, 4, 1), 0, '0);
		add_row(mk(16'hFFDF, 16'h00DC, 16'h0000, 16'h0000, 2, 1), 0, '0);
		add_cfg(1'b0);

		// reset once
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].cfg_row) write_order(steps[i].cfg_val);
			else offer(steps[i].it, steps[i].typed, steps[i].typ);
		end

		// random phases, byte order alternating
		for (int ph = 0; ph < 6; ph++) begin : random_phase
			int start;
			write_order((ph % 2) == 0);
			start = items_taken;
			while (items_taken - start < 340) run_string();
		end

		settle();
		$display("covered %0d items in %0d random strings, %0d results, both byte orders",
			items_taken, strings_sent, results_seen);
		$display("receiver hold-off and drain pauses exercised, %0d errors", errors);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
